### rtl/lctp_pkg.sv
package lctp_pkg;

    localparam int unsigned LCTP_CAPACITY     = 255;
    localparam int unsigned LCTP_REC_BYTES    = 6;
    localparam logic [7:0]  LCTP_LOSS_LEN     = 8'd4;
    localparam int unsigned LCTP_IN_TDATA_W   = 152;
    localparam int unsigned LCTP_OUT_TDATA_W  = 48;

    typedef enum logic [1:0] {
        ACT_STORE,
        ACT_DROP,
        ACT_OUTBOUND,
        ACT_SENT
    } t_action;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_NO_ROOM
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [7:0]  data_byte;
        logic [7:0]  frame_length;
        logic        last;
        logic        held_valid;
        logic [63:0] existing_key;
        logic [63:0] replacement_key;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        status_valid;
        t_status     status;
        logic        record_appended;
        logic        record_updated;
        logic        loss_counted;
        logic [31:0] loss_count;
        logic        loss_pending;
        logic        end_of_run;
    } t_result;

    typedef struct packed {
        logic        start;
        logic        skip_first;
        logic [31:0] frame_count;
        logic [7:0]  record_type;
    } t_append;

endpackage

### rtl/loss_count_tlv_patcher_top.sv
// Lost-packet counter with a type-length-value loss record patcher. Each
// request on the slave stream is a store event, a drop event, an outbound
// frame byte or a sent frame byte (tuser). Requests are taken one per cycle
// unless the output side stalls; each is held in an input register and its first
// result goes to the output register when the core takes it. Every request
// gives one result, except a final outbound byte that appends a six-byte
// loss record: it gives up to seven results, one per cycle while the
// master is ready, and the input stalls while the appended bytes leave
// the output register. The loss record type byte is set through the cfg write
// channel, which is always ready and must be written only while the block is idle.
module loss_count_tlv_patcher_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // data_byte, frame_length, held_valid, existing_key, replacement_key
    input  logic [lctp_pkg::LCTP_IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                                  s_axis_tlast,
    // action
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_byte, status, record_appended, record_updated, loss_counted,
    // loss_count, loss_pending
    output logic [lctp_pkg::LCTP_OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                  m_axis_tlast,
    // byte_valid, status_valid
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [7:0]                            i_cfg_data
);
    import lctp_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    go;
    logic    take_ok;
    t_result core_res;
    t_append core_app;
    t_result out_res;

    assign go            = r_in_valid && take_ok;
    assign s_axis_tready = !r_in_valid || go;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action          <= t_action'(s_axis_tuser);
            r_in.data_byte       <= s_axis_tdata[7:0];
            r_in.frame_length    <= s_axis_tdata[15:8];
            r_in.last            <= s_axis_tlast;
            r_in.held_valid      <= s_axis_tdata[16];
            r_in.existing_key    <= s_axis_tdata[80:17];
            r_in.replacement_key <= s_axis_tdata[144:81];
        end
    end

    lctp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (r_in),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_res       (core_res),
        .o_append    (core_app)
    );

    lctp_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (go),
        .i_res     (core_res),
        .i_append  (core_app),
        .i_m_ready (m_axis_tready),
        .o_take_ok (take_ok),
        .o_m_valid (m_axis_tvalid),
        .o_res     (out_res)
    );

    assign m_axis_tdata = {2'b00,
                           out_res.loss_pending,
                           out_res.loss_count,
                           out_res.loss_counted,
                           out_res.record_updated,
                           out_res.record_appended,
                           out_res.status,
                           out_res.out_byte};
    assign m_axis_tuser = {out_res.status_valid, out_res.byte_valid};
    assign m_axis_tlast = out_res.end_of_run;

endmodule

### rtl/lctp_core.sv
module lctp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  lctp_pkg::t_item   i_item,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    output lctp_pkg::t_result o_res,
    output lctp_pkg::t_append o_append
);
    import lctp_pkg::*;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_SKIP,
        PH_PATCH,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OC_NOT_FOUND,
        OC_FOUND,
        OC_MALFORMED
    } t_outcome;

    logic [7:0]  r_type;
    logic [31:0] r_count, n_count;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_rec_start, n_rec_start;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [2:0]  r_patch_left, n_patch_left;
    t_outcome    r_outcome, n_outcome;
    logic [31:0] r_fc, n_fc;
    logic        r_active, n_active;
    logic        r_sent, n_sent;

    logic        is_frame;
    logic        is_sent;
    logic        start;
    logic        payload;
    logic [7:0]  rem;
    logic [7:0]  ob;
    logic        rep;
    logic        app;
    logic        upd;
    logic        short_frame;
    logic        fits;
    logic [2:0]  pl_dec;
    t_status     st;

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_rec_start  = r_rec_start;
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_patch_left = r_patch_left;
        n_outcome    = r_outcome;
        n_fc         = r_fc;
        n_active     = r_active;
        n_sent       = r_sent;
        rep          = 1'b0;
        app          = 1'b0;
        upd          = 1'b0;
        st           = ST_OK;
        ob           = i_item.data_byte;
        short_frame  = 1'b0;
        pl_dec       = r_patch_left - 3'd1;
        is_sent      = (i_item.action == ACT_SENT);
        is_frame     = (i_item.action == ACT_OUTBOUND) || is_sent;
        start        = !r_active || (r_sent != is_sent);
        payload      = 1'b0;
        rem          = '0;
        fits         = (17'(i_item.frame_length) + 17'(LCTP_REC_BYTES))
                       <= 17'(LCTP_CAPACITY);

        unique case (i_item.action)
            ACT_STORE: begin
                rep = i_item.held_valid
                      && (i_item.existing_key != i_item.replacement_key);
                if (rep && (r_count != '1)) begin
                    n_count = r_count + 32'd1;
                end
            end
            ACT_DROP: begin
                rep = 1'b1;
                if (r_count != '1) begin
                    n_count = r_count + 32'd1;
                end
            end
            ACT_OUTBOUND, ACT_SENT: begin
                if (start) begin
                    n_pos        = '0;
                    n_rec_start  = '0;
                    n_phase      = PH_TYPE;
                    n_kind       = '0;
                    n_patch_left = '0;
                    n_outcome    = OC_NOT_FOUND;
                    n_fc         = r_count;
                end
                n_active = 1'b1;
                n_sent   = is_sent;
                payload  = n_pos < i_item.frame_length;
                rem      = i_item.frame_length - n_pos;
                pl_dec   = n_patch_left - 3'd1;

                if (payload) begin
                    unique case (n_phase)
                        PH_TYPE: begin
                            if (rem < 8'd2) begin
                                n_outcome = OC_MALFORMED;
                                n_phase   = PH_DONE;
                            end else begin
                                n_kind      = i_item.data_byte;
                                n_rec_start = n_pos;
                                n_phase     = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (i_item.data_byte > rem - 8'd1) begin
                                n_outcome = OC_MALFORMED;
                                n_phase   = PH_DONE;
                            end else if (n_kind == r_type) begin
                                if (i_item.data_byte != LCTP_LOSS_LEN) begin
                                    n_outcome = OC_MALFORMED;
                                    n_phase   = PH_DONE;
                                end else begin
                                    n_outcome    = OC_FOUND;
                                    n_patch_left = 3'(LCTP_LOSS_LEN);
                                    n_phase      = PH_PATCH;
                                end
                            end else if (i_item.data_byte == 8'd0) begin
                                n_phase = PH_TYPE;
                            end else begin
                                n_rec_start = n_pos + 8'd1 + i_item.data_byte;
                                n_phase     = PH_SKIP;
                            end
                        end
                        PH_SKIP: begin
                            if ((9'(n_pos) + 9'd1) >= 9'(n_rec_start)) begin
                                n_phase = PH_TYPE;
                            end
                        end
                        PH_PATCH: begin
                            if (!is_sent && (n_fc != '0)) begin
                                unique case (n_patch_left)
                                    3'd4:    ob = n_fc[7:0];
                                    3'd3:    ob = n_fc[15:8];
                                    3'd2:    ob = n_fc[23:16];
                                    3'd1:    ob = n_fc[31:24];
                                    default: ob = n_fc[7:0];
                                endcase
                            end
                            n_patch_left = pl_dec;
                            if ((pl_dec == 3'd0) || (pl_dec > 3'(LCTP_LOSS_LEN))) begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_pos = n_pos + 8'd1;
                end

                if (i_item.last) begin
                    short_frame = n_pos < i_item.frame_length;
                    n_active    = 1'b0;
                    if (is_sent) begin
                        if (!short_frame && (n_outcome == OC_FOUND)) begin
                            n_count = '0;
                        end
                    end else if (n_fc != '0) begin
                        priority if (short_frame || (n_outcome == OC_MALFORMED)) begin
                            st = ST_MALFORMED;
                        end else if (n_outcome == OC_FOUND) begin
                            upd = 1'b1;
                        end else if (fits) begin
                            app = 1'b1;
                        end else begin
                            st = ST_NO_ROOM;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res                   = '0;
        o_res.byte_valid        = is_frame && !is_sent && payload;
        o_res.out_byte          = o_res.byte_valid ? ob : 8'd0;
        o_res.status_valid      = is_frame && !is_sent && i_item.last && !app;
        o_res.status            = o_res.status_valid ? st : ST_OK;
        o_res.record_appended   = 1'b0;
        o_res.record_updated    = o_res.status_valid && upd;
        o_res.loss_counted      = rep;
        o_res.loss_count        = n_count;
        o_res.loss_pending      = is_frame && !is_sent && (n_fc != '0);
        o_res.end_of_run        = !app;

        o_append.start          = app;
        o_append.skip_first     = !payload;
        o_append.frame_count    = n_fc;
        o_append.record_type    = r_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type       <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_rec_start  <= '0;
            r_phase      <= PH_TYPE;
            r_kind       <= '0;
            r_patch_left <= '0;
            r_outcome    <= OC_NOT_FOUND;
            r_fc         <= '0;
            r_active     <= 1'b0;
            r_sent       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_type <= i_cfg_data;
            end
            if (i_go) begin
                r_count      <= n_count;
                r_pos        <= n_pos;
                r_rec_start  <= n_rec_start;
                r_phase      <= n_phase;
                r_kind       <= n_kind;
                r_patch_left <= n_patch_left;
                r_outcome    <= n_outcome;
                r_fc         <= n_fc;
                r_active     <= n_active;
                r_sent       <= n_sent;
            end
        end
    end

    a_patch_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PATCH) |-> (r_outcome == OC_FOUND))
        else $error("patching without a found loss record");

    a_patch_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PATCH) |-> ((r_patch_left != 3'd0)
                                   && (r_patch_left <= 3'(LCTP_LOSS_LEN))))
        else $error("patch byte count out of range");

endmodule

### rtl/lctp_out.sv
module lctp_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  lctp_pkg::t_result i_res,
    input  lctp_pkg::t_append i_append,
    input  logic              i_m_ready,
    output logic              o_take_ok,
    output logic              o_m_valid,
    output lctp_pkg::t_result o_res
);
    import lctp_pkg::*;

    localparam logic [2:0] LAST_IDX = 3'(LCTP_REC_BYTES - 1);

    logic        r_out_valid;
    t_result     r_out;
    logic        r_appending;
    logic [2:0]  r_app_idx;
    logic [31:0] r_app_fc;
    logic [7:0]  r_app_type;
    logic [31:0] r_app_count;

    logic        out_free;
    logic [2:0]  sel_idx;
    logic [31:0] sel_fc;
    logic [7:0]  sel_type;
    logic [31:0] sel_count;
    t_result     app_res;

    assign out_free  = !r_out_valid || i_m_ready;
    assign o_take_ok = out_free && !r_appending;
    assign o_m_valid = r_out_valid;
    assign o_res     = r_out;

    always_comb begin
        sel_idx   = i_go ? 3'd0 : r_app_idx;
        sel_fc    = i_go ? i_append.frame_count : r_app_fc;
        sel_type  = i_go ? i_append.record_type : r_app_type;
        sel_count = i_go ? i_res.loss_count : r_app_count;

        app_res = '0;
        unique case (sel_idx)
            3'd0:    app_res.out_byte = sel_type;
            3'd1:    app_res.out_byte = LCTP_LOSS_LEN;
            3'd2:    app_res.out_byte = sel_fc[7:0];
            3'd3:    app_res.out_byte = sel_fc[15:8];
            3'd4:    app_res.out_byte = sel_fc[23:16];
            3'd5:    app_res.out_byte = sel_fc[31:24];
            default: app_res.out_byte = 8'd0;
        endcase
        app_res.byte_valid      = 1'b1;
        app_res.status_valid    = (sel_idx == LAST_IDX);
        app_res.status          = ST_OK;
        app_res.record_appended = (sel_idx == LAST_IDX);
        app_res.loss_count      = sel_count;
        app_res.loss_pending    = (sel_fc != '0);
        app_res.end_of_run      = (sel_idx == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_appending <= 1'b0;
            r_app_idx   <= '0;
        end else begin
            priority if (i_go) begin
                r_out_valid <= 1'b1;
                r_appending <= i_append.start;
                r_app_idx   <= (i_append.start && i_append.skip_first) ? 3'd1 : 3'd0;
            end else if (r_appending && out_free) begin
                r_out_valid <= 1'b1;
                r_app_idx   <= r_app_idx + 3'd1;
                if (r_app_idx == LAST_IDX) begin
                    r_appending <= 1'b0;
                end
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_out       <= (i_append.start && i_append.skip_first) ? app_res : i_res;
            r_app_fc    <= i_append.frame_count;
            r_app_type  <= i_append.record_type;
            r_app_count <= i_res.loss_count;
        end else if (r_appending && out_free) begin
            r_out <= app_res;
        end
    end

    a_append_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_appending |-> r_out_valid)
        else $error("append in progress with empty output register");

    a_append_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_appending |-> (r_app_idx <= LAST_IDX))
        else $error("append index out of range");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status_valid) |-> r_out.end_of_run)
        else $error("status on a result that is not the last of its run");

    a_append_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_append.start) |=> r_appending)
        else $error("append request not taken");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lctp_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        W_TYPE,
        W_LEN,
        W_SKIP,
        W_PATCH,
        W_DONE
    } t_walk;

    typedef enum logic [1:0] {
        F_NONE,
        F_FOUND,
        F_BAD
    } t_find;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [LCTP_IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                        s_axis_tlast = 1'b0;
    logic [1:0]                  s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [LCTP_OUT_TDATA_W-1:0] m_axis_tdata;
    logic                        m_axis_tlast;
    logic [1:0]                  m_axis_tuser;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [7:0]                  i_cfg_data = '0;

    // patcher state as seen from outside
    logic [7:0]  rec_type = '0;
    logic [31:0] lost_cnt = '0;
    logic [7:0]  pos = '0;
    logic [7:0]  r_start = '0;
    logic [7:0]  r_kind = '0;
    logic [2:0]  p_left = '0;
    t_walk       w_ph = W_TYPE;
    t_find       outc = F_NONE;
    logic [31:0] frame_cnt = '0;
    bit          frame_on = 1'b0;
    bit          frame_is_sent = 1'b0;

    t_item       req_q[$];
    t_result     patcher_out_q[$];
    t_item       on_bus;
    logic [7:0]  fbody[$];

    int unsigned cyc = 0;
    int unsigned idle_cyc = 0;
    int unsigned hold_left = 0;
    bit          hold_go = 1'b0;
    bit          hold_used = 1'b0;
    bit          quiet;
    int          n_bad = 0;
    int          n_in = 0;
    int          n_out = 0;
    int          n_app = 0;
    int          n_upd = 0;
    int          n_malf = 0;
    int          n_room = 0;
    int          n_clr = 0;
    int          n_lost = 0;

    loss_count_tlv_patcher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    assign quiet = (cyc % 3000) < 700;

    function automatic logic [7:0] walk_step(logic [7:0] b, int unsigned tot, bit patching);
        int unsigned p;
        logic [7:0]  ob;
        p = pos;
        ob = b;
        case (w_ph)
            W_TYPE: begin
                if (tot - p < 2) begin
                    outc = F_BAD;
                    w_ph = W_DONE;
                end else begin
                    r_kind = b;
                    r_start = p[7:0];
                    w_ph = W_LEN;
                end
            end
            W_LEN: begin
                if (b > tot - p - 1) begin
                    outc = F_BAD;
                    w_ph = W_DONE;
                end else if (r_kind == rec_type) begin
                    if (b != LCTP_LOSS_LEN) begin
                        outc = F_BAD;
                        w_ph = W_DONE;
                    end else begin
                        outc = F_FOUND;
                        p_left = 3'd4;
                        w_ph = W_PATCH;
                    end
                end else if (b == 8'd0) begin
                    w_ph = W_TYPE;
                end else begin
                    r_start = 8'(p + 1 + b);
                    w_ph = W_SKIP;
                end
            end
            W_SKIP: begin
                if (p + 1 >= r_start) w_ph = W_TYPE;
            end
            W_PATCH: begin
                if (patching) ob = 8'(frame_cnt >> (8 * (4 - p_left)));
                p_left = p_left - 3'd1;
                if (p_left == 3'd0) w_ph = W_DONE;
            end
            default: ;
        endcase
        return ob;
    endfunction

    function automatic void bump_loss();
        if (lost_cnt != 32'hFFFF_FFFF) lost_cnt = lost_cnt + 1;
        n_lost++;
    endfunction

    // expected results for one accepted request
    function automatic void run_patcher(t_item it);
        t_result     r[7];
        int          n;
        bit          sent;
        bit          pay;
        bit          pend;
        bit          shrt;
        bit          app;
        bit          upd;
        t_status     st;
        logic [7:0]  ob;
        int unsigned flen;
        logic [7:0]  rec[6];
        foreach (r[k]) r[k] = '0;
        n = 0;
        if (it.action == ACT_STORE) begin
            if (it.held_valid && it.existing_key != it.replacement_key) begin
                bump_loss();
                r[0].loss_counted = 1'b1;
            end
            n = 1;
        end else if (it.action == ACT_DROP) begin
            bump_loss();
            r[0].loss_counted = 1'b1;
            n = 1;
        end else begin
            sent = (it.action == ACT_SENT);
            flen = it.frame_length;
            if (!frame_on || frame_is_sent != sent) begin
                frame_on = 1'b1;
                frame_is_sent = sent;
                pos = '0;
                r_start = '0;
                w_ph = W_TYPE;
                r_kind = '0;
                p_left = '0;
                outc = F_NONE;
                frame_cnt = lost_cnt;
            end
            pend = !sent && frame_cnt != 0;
            pay = pos < flen;
            ob = it.data_byte;
            if (pay) begin
                ob = walk_step(it.data_byte, flen, pend);
                pos = pos + 8'd1;
            end
            if (!sent && pay) begin
                r[0].out_byte = ob;
                r[0].byte_valid = 1'b1;
            end
            r[0].loss_pending = pend;
            n = ((!sent && pay) || !it.last) ? 1 : 0;
            if (it.last) begin
                shrt = pos < flen;
                frame_on = 1'b0;
                if (sent) begin
                    if (!shrt && outc == F_FOUND) begin
                        lost_cnt = '0;
                        n_clr++;
                    end
                end else begin
                    st = ST_OK;
                    app = 1'b0;
                    upd = 1'b0;
                    if (frame_cnt != 0) begin
                        if (shrt || outc == F_BAD) begin
                            st = ST_MALFORMED;
                            n_malf++;
                        end else if (outc == F_FOUND) begin
                            upd = 1'b1;
                            n_upd++;
                        end else if (flen + LCTP_REC_BYTES <= LCTP_CAPACITY) begin
                            rec[0] = rec_type;
                            rec[1] = LCTP_LOSS_LEN;
                            rec[2] = frame_cnt[7:0];
                            rec[3] = frame_cnt[15:8];
                            rec[4] = frame_cnt[23:16];
                            rec[5] = frame_cnt[31:24];
                            for (int k = 0; k < 6; k++) begin
                                r[n].out_byte = rec[k];
                                r[n].byte_valid = 1'b1;
                                r[n].loss_pending = pend;
                                n++;
                            end
                            app = 1'b1;
                            n_app++;
                        end else begin
                            st = ST_NO_ROOM;
                            n_room++;
                        end
                    end
                    if (n == 0) n = 1;
                    r[n-1].status_valid = 1'b1;
                    r[n-1].status = st;
                    r[n-1].record_appended = app;
                    r[n-1].record_updated = upd;
                end
                if (n == 0) n = 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            r[k].loss_count = lost_cnt;
            r[k].end_of_run = (k == n - 1);
            patcher_out_q.push_back(r[k]);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                run_patcher(on_bus);
                n_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_q.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
                    on_bus = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'd0, on_bus.replacement_key, on_bus.existing_key,
                                     on_bus.held_valid, on_bus.frame_length,
                                     on_bus.data_byte};
                    s_axis_tlast <= on_bus.last;
                    s_axis_tuser <= on_bus.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || $urandom_range(99) >= 6;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_out++;
                got.out_byte = m_axis_tdata[7:0];
                got.status = t_status'(m_axis_tdata[9:8]);
                got.record_appended = m_axis_tdata[10];
                got.record_updated = m_axis_tdata[11];
                got.loss_counted = m_axis_tdata[12];
                got.loss_count = m_axis_tdata[44:13];
                got.loss_pending = m_axis_tdata[45];
                got.byte_valid = m_axis_tuser[0];
                got.status_valid = m_axis_tuser[1];
                got.end_of_run = m_axis_tlast;
                if (patcher_out_q.size() == 0) begin
                    if (n_bad < 10) $display("unexpected result %h at %0t", got, $realtime);
                    n_bad++;
                end else begin
                    want = patcher_out_q.pop_front();
                    if (got !== want) begin
                        if (n_bad < 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  exp byte=%h bv=%b sv=%b st=%0d app=%b upd=%b",
                                     want.out_byte, want.byte_valid, want.status_valid,
                                     want.status, want.record_appended,
                                     want.record_updated);
                            $display("      lost=%b cnt=%h pend=%b eor=%b",
                                     want.loss_counted, want.loss_count, want.loss_pending,
                                     want.end_of_run);
                            $display("  got byte=%h bv=%b sv=%b st=%0d app=%b upd=%b",
                                     got.out_byte, got.byte_valid, got.status_valid,
                                     got.status, got.record_appended,
                                     got.record_updated);
                            $display("      lost=%b cnt=%h pend=%b eor=%b",
                                     got.loss_counted, got.loss_count, got.loss_pending,
                                     got.end_of_run);
                        end
                        n_bad++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cyc <= 0;
            end else begin
                idle_cyc <= idle_cyc + 1;
            end
            if (idle_cyc >= STALL_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", idle_cyc);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic set_rec_type(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rec_type = v;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (req_q.size() != 0 || s_axis_tvalid || patcher_out_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic queue_item(t_action a, logic [7:0] db, logic [7:0] fl, bit lst);
        t_item it;
        it.action = a;
        it.data_byte = db;
        it.frame_length = fl;
        it.last = lst;
        it.held_valid = 1'($urandom_range(1));
        it.existing_key = {$urandom, $urandom};
        it.replacement_key = {$urandom, $urandom};
        req_q.push_back(it);
    endtask

    task automatic queue_store(bit ev, logic [63:0] ek, logic [63:0] rk);
        t_item it;
        it.action = ACT_STORE;
        it.data_byte = 8'($urandom);
        it.frame_length = 8'($urandom);
        it.last = 1'($urandom_range(1));
        it.held_valid = ev;
        it.existing_key = ek;
        it.replacement_key = rk;
        req_q.push_back(it);
    endtask

    task automatic queue_event();
        logic [63:0] ek;
        ek = {$urandom, $urandom};
        if ($urandom_range(1)) begin
            queue_item(ACT_DROP, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end else if ($urandom_range(99) < 40) begin
            queue_store(1'($urandom_range(1)), ek, ek);
        end else begin
            queue_store(1'($urandom_range(1)), ek, {$urandom, $urandom});
        end
    endtask

    task automatic queue_frame(t_action a, int flen, bit fin);
        if (fbody.size() == 0) begin
            if (fin) queue_item(a, 8'($urandom), 8'(flen), 1'b1);
        end else begin
            for (int i = 0; i < fbody.size(); i++) begin
                if ($urandom_range(99) < 4) queue_event();
                queue_item(a, fbody[i], 8'(flen), fin && i == fbody.size() - 1);
            end
        end
    endtask

    // records with random content, well-formed except that a loss-type record may carry a length other than four
    task automatic gen_body(int target);
        logic [7:0] ty;
        int         ln;
        fbody.delete();
        while (fbody.size() < target) begin
            if ($urandom_range(99) < 35) begin
                ty = rec_type;
                ln = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 4;
            end else begin
                ty = 8'($urandom);
                ln = $urandom_range(0, 5);
            end
            if (fbody.size() + 2 + ln > LCTP_CAPACITY) break;
            fbody.push_back(ty);
            fbody.push_back(8'(ln));
            repeat (ln) fbody.push_back(8'($urandom));
        end
    endtask

    task automatic rand_frame();
        t_action a;
        int      mode;
        int      flen;
        int      cut;
        bit      fin;
        a = ($urandom_range(99) < 75) ? ACT_OUTBOUND : ACT_SENT;
        gen_body($urandom_range(0, 20));
        flen = fbody.size();
        fin = 1'b1;
        mode = $urandom_range(99);
        if (mode < 8) begin
            flen = flen + $urandom_range(1, 4);
            if (flen > 255) flen = 255;
        end else if (mode < 14) begin
            repeat ($urandom_range(1, 3)) fbody.push_back(8'($urandom));
        end else if (mode < 20 && fbody.size() > 0) begin
            cut = $urandom_range(fbody.size() - 1);
            while (fbody.size() > cut) void'(fbody.pop_back());
            flen = fbody.size();
        end else if (mode < 24) begin
            // abandoned midway, next frame takes over
            fin = 1'b0;
        end else if (mode < 28) begin
            fbody.delete();
            repeat ($urandom_range(0, 12)) fbody.push_back(8'($urandom));
            flen = (mode == 27) ? 255 : fbody.size();
        end
        queue_frame(a, flen, fin);
    endtask

    task automatic rand_phase(int n_items);
        while (req_q.size() < n_items) begin
            if ($urandom_range(99) < 30) queue_event();
            else rand_frame();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_rec_type(8'h3C);
        // count zero, frame passes untouched
        fbody = '{8'h01, 8'h01, 8'hAA};
        queue_frame(ACT_OUTBOUND, 3, 1'b1);
        queue_store(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        queue_store(1'b1, 64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF);
        queue_store(1'b0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(ACT_DROP, 8'hFF, 8'hFF, 1'b1);
        // loss record overwritten in place
        fbody = '{8'h3C, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44};
        queue_frame(ACT_OUTBOUND, 6, 1'b1);
        // empty frame gets a record appended
        fbody.delete();
        queue_frame(ACT_OUTBOUND, 0, 1'b1);
        // length running past the frame
        fbody = '{8'h3C, 8'h05};
        queue_frame(ACT_OUTBOUND, 2, 1'b1);
        // sent frame with a loss record clears the count
        fbody = '{8'h3C, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_frame(ACT_SENT, 6, 1'b1);
        fbody = '{8'h01, 8'h00};
        queue_frame(ACT_OUTBOUND, 2, 1'b1);
        drain();

        set_rec_type(8'hFF);
        rand_phase(15);
        drain();

        set_rec_type(8'($urandom));
        rand_phase(15);
        @(negedge i_clk);
        hold_go = 1'b1;
        drain();

        set_rec_type(8'h00);
        rand_phase(10);
        // one long frame with no room left for the record
        queue_item(ACT_DROP, 8'h00, 8'h00, 1'b0);
        fbody.delete();
        fbody.push_back(rec_type ^ 8'h01);
        fbody.push_back(8'd248);
        repeat (248) fbody.push_back(8'($urandom));
        queue_frame(ACT_OUTBOUND, 250, 1'b1);
        rand_phase(req_q.size() + 8);
        drain();

        set_rec_type(8'($urandom));
        rand_phase(15);
        drain();

        repeat (20) @(posedge i_clk);
        n_bad += patcher_out_q.size();
        $display("%0d requests in, %0d results out, %0d losses counted, %0d clears",
                 n_in, n_out, n_lost, n_clr);
        $display("records appended %0d, updated %0d, malformed %0d, no room %0d",
                 n_app, n_upd, n_malf, n_room);
        if (n_bad == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
